### rtl/nts_pkg.sv
// Shared types and constants of the nearest timestamp sample matcher.
package nts_pkg;

  localparam int NTS_QUEUE_DEPTH = 128;
  localparam int TIME_W          = 63;
  localparam int QUAT_W          = 16;
  localparam int DELAY_W         = 30;
  localparam int APB_ADDR_W      = 3;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 30'd10000000;
  localparam logic [TIME_W-1:0]  GAP_MAX     = {TIME_W{1'b1}};

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index
  localparam logic REG_MAX_DELAY = 1'b0;

  // one stored sample
  typedef struct packed {
    logic [TIME_W-1:0]   time_ns;
    logic [4*QUAT_W-1:0] quat;
  } nts_entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic load;
  } nts_cell_ctrl_t;

endpackage

### rtl/nts_if.sv
// Handshake channels for input items and result items.
interface nts_in_if;
  import nts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [TIME_W-1:0]        event_time_ns;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  modport source (output valid, operation, event_time_ns, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink (input valid, operation, event_time_ns, quat_w, quat_x, quat_y, quat_z,
                output ready);
endinterface

interface nts_out_if;
  import nts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     matched;
  logic [TIME_W-1:0]        best_gap_ns;
  logic signed [QUAT_W-1:0] match_w;
  logic signed [QUAT_W-1:0] match_x;
  logic signed [QUAT_W-1:0] match_y;
  logic signed [QUAT_W-1:0] match_z;
  modport source (output valid, matched, best_gap_ns, match_w, match_x, match_y, match_z,
                  input ready);
  modport sink (input valid, matched, best_gap_ns, match_w, match_x, match_y, match_z,
                output ready);
endinterface

### rtl/nts_cell.sv
// One queue cell: holds a sample, loads a new one or takes its upper neighbor's.
module nts_cell #(
  parameter int IDX_W  = 7,
  parameter int MY_IDX = 0
) (
  input  logic                clk,
  input  nts_pkg::nts_cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    load_idx,
  input  nts_pkg::nts_entry_t load_data,
  input  nts_pkg::nts_entry_t upper,
  output nts_pkg::nts_entry_t data
);
  import nts_pkg::*;

  nts_entry_t data_r;
  logic       hit;

  assign hit  = ctrl.load && (load_idx == IDX_W'(MY_IDX));
  assign data = data_r;

  // load wins over shift so a push into a full queue lands at the tail
  always_ff @(posedge clk) begin
    if (hit) begin
      data_r <= load_data;
    end else if (ctrl.shift) begin
      data_r <= upper;
    end
  end
endmodule

### rtl/nts_cfg.sv
// APB register holding the largest accepted gap.
module nts_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [nts_pkg::DELAY_W-1:0]    delay_lim
);
  import nts_pkg::*;

  logic [DELAY_W-1:0] delay_r;
  logic               sel0;

  assign sel0      = (paddr[2] == REG_MAX_DELAY);
  assign pready    = 1'b1;
  assign delay_lim = delay_r;
  assign prdata    = sel0 ? {{(32-DELAY_W){1'b0}}, delay_r} : 32'd0;

  // write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (psel && penable && pwrite && sel0) begin
      delay_r <= pwdata[DELAY_W-1:0];
    end
  end
endmodule

### rtl/nearest_timestamp_sample_matcher.sv
// Top level of the nearest timestamp sample matcher.
// Samples sit in a row of QUEUE_DEPTH cells that shift toward the head; a push
// writes the tail (dropping the oldest sample when full) and a query examines
// the head cell once per cycle, popping each entry it compares until the queue
// is empty or the head is newer than the frame time by more than the limit.
// A query runs through the accepting cycle, the head compare of each popped
// entry, and a closing step that loads the result; the closing step also waits
// while the output register still holds a result that has not been taken.
// Input items are taken only while no query is being scanned; a finished
// result waits in the output register while pushes keep arriving.
module nearest_timestamp_sample_matcher #(
  parameter int QUEUE_DEPTH = nts_pkg::NTS_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nts_in_if.sink                         in_ch,
  nts_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import nts_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] TAIL_IDX = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic               state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  frame_r;
  logic [TIME_W-1:0]  best_r;
  logic [4*QUAT_W-1:0] bestq_r;
  logic               have_r;
  logic               ov_r;
  logic               omatch_r;
  logic [TIME_W-1:0]  ogap_r;
  logic [4*QUAT_W-1:0] oq_r;

  logic [DELAY_W-1:0] delay_lim;
  nts_cell_ctrl_t     ctrl;
  logic [IDX_W-1:0]   load_idx;
  nts_entry_t         load_data;
  nts_entry_t         cells [QUEUE_DEPTH];

  logic               in_acc, full, newer, too_new, stop, take, out_free;
  logic [TIME_W-1:0]  diff;
  nts_entry_t         head;

  nts_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .delay_lim
  );

  // row of cells, each fed by its upper neighbor
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    nts_entry_t upper;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    nts_cell #(.IDX_W(IDX_W), .MY_IDX(i)) u_cell (
      .clk, .ctrl, .load_idx, .load_data, .upper, .data(cells[i])
    );
  end

  assign head     = cells[0];
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign full     = (count_r == CNT_FULL);
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // head compare against the frame time
  assign newer   = head.time_ns > frame_r;
  assign diff    = newer ? head.time_ns - frame_r : frame_r - head.time_ns;
  assign too_new = newer && (diff > {{(TIME_W-DELAY_W){1'b0}}, delay_lim});
  assign stop    = (count_r == '0) || too_new;
  assign take    = !have_r || (diff < best_r);

  assign load_data = '{time_ns: in_ch.event_time_ns,
                       quat: {in_ch.quat_w, in_ch.quat_x, in_ch.quat_y, in_ch.quat_z}};

  // cell control and next state
  always_comb begin
    ctrl      = '0;
    load_idx  = count_r[IDX_W-1:0];
    count_nxt = count_r;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_PUSH) begin
            ctrl.load = 1'b1;
            if (full) begin
              ctrl.shift = 1'b1;
              load_idx   = TAIL_IDX;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stop) begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          ctrl.shift = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == ST_SCAN && stop && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // scan tracking and result hold
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_ch.operation == OP_QUERY) begin
      frame_r <= in_ch.event_time_ns;
      best_r  <= GAP_MAX;
      bestq_r <= '0;
      have_r  <= 1'b0;
    end else if (state_r == ST_SCAN && !stop && take) begin
      best_r  <= diff;
      bestq_r <= head.quat;
      have_r  <= 1'b1;
    end
    if (state_r == ST_SCAN && stop && out_free) begin
      omatch_r <= have_r && (best_r <= {{(TIME_W-DELAY_W){1'b0}}, delay_lim});
      ogap_r   <= best_r;
      oq_r     <= bestq_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.matched     = omatch_r;
  assign out_ch.best_gap_ns = ogap_r;
  assign out_ch.match_w     = oq_r[4*QUAT_W-1:3*QUAT_W];
  assign out_ch.match_x     = oq_r[3*QUAT_W-1:2*QUAT_W];
  assign out_ch.match_y     = oq_r[2*QUAT_W-1:QUAT_W];
  assign out_ch.match_z     = oq_r[QUAT_W-1:0];
endmodule
